@@ rtl/ljc_pkg.sv @@
// ----------------------------------------------------------------------------
// ljc_pkg: shared types and constants for the line follower junction counter
// Word layouts, motion codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package ljc_pkg;

  // default width of the marker counter
  localparam int COUNT_BITS_DEF = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_BOOST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_MODE  = 3'd5;

  // register reset values
  localparam logic [3:0] TARGET_COUNT_RST = 4'd5;
  localparam logic [7:0] START_SPEED_RST  = 8'd60;
  localparam logic [7:0] MIN_SPEED_RST    = 8'd35;
  localparam logic [5:0] DECEL_STEP_RST   = 6'd5;
  localparam logic [5:0] TURN_BOOST_RST   = 6'd10;
  localparam logic       MARKER_MODE_RST  = 1'b0;

  // motion codes
  localparam logic [2:0] MOT_STOP  = 3'd0;
  localparam logic [2:0] MOT_ADV   = 3'd1;
  localparam logic [2:0] MOT_RIGHT = 3'd2;
  localparam logic [2:0] MOT_LEFT  = 3'd3;
  localparam logic [2:0] MOT_KEEP  = 3'd4;

  // input word
  typedef struct packed {
    logic sense_left;
    logic sense_mid;
    logic sense_right;
    logic run_start;
    logic estop;
  } ljc_in_t;

  // output word
  typedef struct packed {
    logic [2:0] motion;
    logic [7:0] drive_speed;
    logic [3:0] crossed;
    logic       run_done;
    logic       run_aborted;
  } ljc_out_t;

  // configuration register file contents
  typedef struct packed {
    logic [3:0] target_count;
    logic [7:0] start_speed;
    logic [7:0] min_speed;
    logic [5:0] decel_step;
    logic [5:0] turn_boost;
    logic       marker_mode;
  } ljc_cfg_t;

endpackage

@@ rtl/ljc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ljc_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module ljc_cfg_regs
  import ljc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ljc_cfg_t              cfg
);

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_count <= TARGET_COUNT_RST;
      cfg.start_speed  <= START_SPEED_RST;
      cfg.min_speed    <= MIN_SPEED_RST;
      cfg.decel_step   <= DECEL_STEP_RST;
      cfg.turn_boost   <= TURN_BOOST_RST;
      cfg.marker_mode  <= MARKER_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_COUNT: cfg.target_count <= cfg_data[3:0];
        REG_START_SPEED:  cfg.start_speed  <= cfg_data[7:0];
        REG_MIN_SPEED:    cfg.min_speed    <= cfg_data[7:0];
        REG_DECEL_STEP:   cfg.decel_step   <= cfg_data[5:0];
        REG_TURN_BOOST:   cfg.turn_boost   <= cfg_data[5:0];
        REG_MARKER_MODE:  cfg.marker_mode  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/ljc_speed.sv @@
// ----------------------------------------------------------------------------
// ljc_speed: drive speed from the marker count
// start_speed minus count times decel_step, floored at min_speed, plus a
// saturated turn speed.
// ----------------------------------------------------------------------------
module ljc_speed
  import ljc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] cnt,
  input  ljc_cfg_t              cfg,
  output logic [7:0]            speed,
  output logic [7:0]            boosted
);

  localparam int DW = COUNT_BITS + 6;
  localparam int MW = COUNT_BITS + 8;

  logic [DW-1:0] dec;
  logic          dec_ge;
  logic [7:0]    raw;
  logic [8:0]    sum;

  // deceleration and floor
  always_comb begin
    dec    = DW'(cnt) * DW'(cfg.decel_step);
    dec_ge = MW'(dec) >= MW'(cfg.start_speed);
    // dec is below start_speed here, so its low byte is exact
    raw    = dec_ge ? 8'd0 : (cfg.start_speed - dec[7:0]);
    speed  = (raw < cfg.min_speed) ? cfg.min_speed : raw;
  end

  // turn boost, saturating
  always_comb begin
    sum     = {1'b0, speed} + {3'b000, cfg.turn_boost};
    boosted = sum[8] ? 8'hFF : sum[7:0];
  end

endmodule

@@ rtl/ljc_step.sv @@
// ----------------------------------------------------------------------------
// ljc_step: run state and per-word decode
// Holds the marker count, on-marker flag and running flag, decodes one sensor
// word into a result and updates the state when the word moves on.
// ----------------------------------------------------------------------------
module ljc_step
  import ljc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  ljc_in_t  item,
  input  ljc_cfg_t cfg,
  output ljc_out_t result
);

  localparam int CW = COUNT_BITS + 4;

  logic [COUNT_BITS-1:0] cnt;
  logic                  on_marker;
  logic                  running;

  logic [COUNT_BITS-1:0] cnt_next;
  logic                  on_marker_next;
  logic                  running_next;

  logic [COUNT_BITS-1:0] cnt0;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  om0;
  logic                  run0;
  logic                  marker;
  logic                  gap;
  logic [7:0]            speed;
  logic [7:0]            boosted;
  logic [CW-1:0]         cnt_wide;

  ljc_speed #(
    .COUNT_BITS (COUNT_BITS)
  ) u_speed (
    .cnt     (cnt0),
    .cfg     (cfg),
    .speed   (speed),
    .boosted (boosted)
  );

  // decode and next state
  always_comb begin
    cnt0    = item.run_start ? '0 : cnt;
    om0     = item.run_start | on_marker;
    run0    = item.run_start | running;
    cnt_inc = cnt0 + COUNT_BITS'(1);
    marker  = cfg.marker_mode ? (item.sense_mid & item.sense_right)
                              : (item.sense_left & item.sense_mid & item.sense_right);
    gap     = item.sense_left & ~item.sense_mid & item.sense_right;

    cnt_next           = cnt0;
    on_marker_next     = om0;
    running_next       = run0;
    result.motion      = MOT_STOP;
    result.drive_speed = 8'd0;
    result.run_done    = 1'b0;
    result.run_aborted = 1'b0;

    if (!run0) begin
      // idle: stop, estop ignored
    end else if (CW'(cnt0) >= CW'(cfg.target_count)) begin
      // target already met
      running_next    = 1'b0;
      result.run_done = 1'b1;
    end else begin
      if (marker) begin
        result.motion      = MOT_ADV;
        result.drive_speed = speed;
        if (!om0) begin
          cnt_next       = cnt_inc;
          on_marker_next = 1'b1;
        end
      end else if (gap) begin
        result.motion = MOT_KEEP;
      end else begin
        on_marker_next = 1'b0;
        if (!item.sense_left && !item.sense_right) begin
          result.motion      = MOT_ADV;
          result.drive_speed = speed;
        end else if (item.sense_right) begin
          result.motion      = MOT_RIGHT;
          result.drive_speed = boosted;
        end else begin
          result.motion      = MOT_LEFT;
          result.drive_speed = boosted;
        end
      end

      if (marker && !om0 && (CW'(cnt_inc) >= CW'(cfg.target_count))) begin
        // target reached on this crossing, estop ignored
        running_next       = 1'b0;
        result.motion      = MOT_STOP;
        result.drive_speed = 8'd0;
        result.run_done    = 1'b1;
      end else if (item.estop) begin
        // abort; the count update still stands
        running_next       = 1'b0;
        result.motion      = MOT_STOP;
        result.drive_speed = 8'd0;
        result.run_aborted = 1'b1;
      end
    end

    cnt_wide       = {4'b0000, cnt_next};
    result.crossed = cnt_wide[3:0];
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      on_marker <= 1'b1;
      running   <= 1'b0;
    end else if (adv) begin
      cnt       <= cnt_next;
      on_marker <= on_marker_next;
      running   <= running_next;
    end
  end

endmodule

@@ rtl/line_follow_junction_counter.sv @@
// ----------------------------------------------------------------------------
// line_follow_junction_counter: three-sensor line follower with marker count
// Input register, combinational decode with registered state update, result register.
// ----------------------------------------------------------------------------
// Takes one sensor word per clock and returns one result word per input word,
// in order. An accepted word is held in the input register while the decode and
// counter update feed the result register, from which it appears at the output.
// The run state updates together with the result register load, so words may
// follow back to back with no bubbles; throughput is one word per clock while the
// output side keeps taking words. Configuration writes take effect on the next
// clock and should be made only while no words are in flight.
module line_follow_junction_counter
  import ljc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ljc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ljc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ljc_cfg_t cfg;
  ljc_in_t  s1_data;
  logic     s1_valid;
  logic     s2_ready;
  logic     adv;
  ljc_out_t result;

  ljc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow control
  assign s2_ready = ~out_valid | out_ready;
  assign in_ready = ~s1_valid | s2_ready;
  assign adv      = s1_valid & s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  ljc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (s1_data),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/ljc_checker.sv @@
// ----------------------------------------------------------------------------
// ljc_checker: port-level checks for the line follower junction counter
// Watches the top-level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module ljc_checker
  import ljc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input ljc_out_t              out_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a run ends in one way only
  a_end_once: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.run_done && out_data.run_aborted))
    else $error("run both done and aborted");

  // run end always stops the drive
  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.run_done || out_data.run_aborted)
      |-> out_data.motion == MOT_STOP && out_data.drive_speed == 8'd0)
    else $error("run ended without a stop");

  // stop and keep carry no speed
  a_idle_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.motion == MOT_STOP || out_data.motion == MOT_KEEP)
      |-> out_data.drive_speed == 8'd0)
    else $error("speed on stop or keep");

endmodule

bind line_follow_junction_counter ljc_checker u_ljc_checker (.*);
